/* rtl/cse_pkg.sv */
// cse_pkg: shared types and codes for the counting sort engine
// no dependencies; imported by cse_alu and counting_sort_engine_top
package cse_pkg;

   // operation select for the shared add/subtract unit
   typedef logic alu_op_type;

   localparam alu_op_type ALU_ADD = 1'b0;
   localparam alu_op_type ALU_SUB = 1'b1;

   // control word that the sequencer hands to the shared unit
   typedef struct packed {
      alu_op_type op;
   } alu_ctl_type;

endpackage

/* rtl/cse_alu.sv */
// cse_alu: shared add/subtract unit of the counting sort engine
// depends on cse_pkg for the operation codes and control word
module cse_alu #(
   parameter int WIDTH = 6
) (
   input  cse_pkg::alu_ctl_type ctl,
   input  logic [WIDTH-1:0]     a_in,
   input  logic [WIDTH-1:0]     b_in,
   output logic [WIDTH-1:0]     y_out
);
   import cse_pkg::*;

   // histogram increment, prefix accumulate and slot decrement all come here
   always_comb begin
      unique case (ctl.op)
         ALU_ADD: y_out = a_in + b_in;
         ALU_SUB: y_out = a_in - b_in;
         default: y_out = a_in;
      endcase
   end

endmodule

/* rtl/cse_ram.sv */
// cse_ram: simple dual-port memory, one write and one registered read per cycle
// no dependencies; used for the item store, output store and histogram
module cse_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/counting_sort_engine_top.sv */
// counting_sort_engine_top: stable counting sort with a shared add/subtract unit
// loading takes one beat per cycle; after the last beat a turnaround state, then prefix over
// bins min..max, placement per item in S_PL_ITEM, S_PL_HIST, S_PL_WRITE, emit per result in
// S_EM_RD, S_EM_LOAD, S_EM_WAIT plus sink stall, then histogram clear of bins min..max before
// the next set is taken; reset: synchronous, active high, then a clearing pass over all
// 2^VALUE_BITS bins during which req_tready stays low; depends on cse_pkg, cse_alu, cse_ram
module counting_sort_engine_top #(
   parameter int MAX_ITEMS  = 32,
   parameter int VALUE_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] value
   input  logic       req_tlast,
   // result channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] sorted_value
   output logic       rsp_tlast
);
   import cse_pkg::*;

   localparam int VB = VALUE_BITS;
   localparam int NB = 1 << VALUE_BITS;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_LOAD     = 4'd1;
   localparam logic [3:0] S_LOAD_END = 4'd2;
   localparam logic [3:0] S_PREFIX   = 4'd3;
   localparam logic [3:0] S_PL_ITEM  = 4'd4;
   localparam logic [3:0] S_PL_HIST  = 4'd5;
   localparam logic [3:0] S_PL_WRITE = 4'd6;
   localparam logic [3:0] S_EM_RD    = 4'd7;
   localparam logic [3:0] S_EM_LOAD  = 4'd8;
   localparam logic [3:0] S_EM_WAIT  = 4'd9;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [VB-1:0] min_ff, min_in;
   logic [VB-1:0] max_ff, max_in;
   logic [VB-1:0] clr_addr_ff, clr_addr_in;
   logic [VB-1:0] clr_end_ff, clr_end_in;
   logic          p_valid_ff, p_valid_in;
   logic [VB-1:0] p_addr_ff, p_addr_in;
   logic          w_valid_ff, w_valid_in;
   logic [VB-1:0] w_addr_ff, w_addr_in;
   logic [CW-1:0] w_data_ff, w_data_in;
   logic [CW-1:0] acc_ff, acc_in;
   logic [VB-1:0] bin_ff, bin_in;
   logic          bin_done_ff, bin_done_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [VB-1:0] x_ff, x_in;
   logic [IW-1:0] em_idx_ff, em_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [VB-1:0] in_value;
   logic          in_accept;
   logic          in_store;

   logic          item_we;
   logic [VB-1:0] item_rd;
   logic          out_we;
   logic [IW-1:0] out_waddr;
   logic [VB-1:0] out_rd;
   logic          hist_we;
   logic [VB-1:0] hist_waddr;
   logic [CW-1:0] hist_wdata;
   logic [VB-1:0] hist_raddr;
   logic [CW-1:0] hist_rd;

   alu_ctl_type   alu_ctl;
   logic [CW-1:0] alu_a;
   logic [CW-1:0] alu_b;
   logic [CW-1:0] alu_y;

   // input beat decode
   assign in_value  = VB'(req_tdata);
   assign req_tready = (state_ff == S_LOAD);
   assign in_accept = req_tvalid && req_tready;
   assign in_store  = in_accept && (count_ff < CW'(MAX_ITEMS));
   assign item_we   = in_store;

   // storage
   cse_ram #(.DEPTH(MAX_ITEMS), .WIDTH(VB)) u_item_store (
      .clock   (clock),
      .wr_en   (item_we),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (in_value),
      .rd_addr (idx_ff),
      .rd_data (item_rd)
   );

   cse_ram #(.DEPTH(MAX_ITEMS), .WIDTH(VB)) u_output_store (
      .clock   (clock),
      .wr_en   (out_we),
      .wr_addr (out_waddr),
      .wr_data (x_ff),
      .rd_addr (em_idx_ff),
      .rd_data (out_rd)
   );

   cse_ram #(.DEPTH(NB), .WIDTH(CW)) u_histogram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_addr (hist_raddr),
      .rd_data (hist_rd)
   );

   cse_alu #(.WIDTH(CW)) u_alu (
      .ctl   (alu_ctl),
      .a_in  (alu_a),
      .b_in  (alu_b),
      .y_out (alu_y)
   );

   // operand routing for the shared unit and histogram port selection
   always_comb begin
      alu_ctl.op = ALU_ADD;
      alu_a      = hist_rd;
      alu_b      = CW'(1);
      hist_we    = 1'b0;
      hist_waddr = p_addr_ff;
      hist_wdata = alu_y;
      hist_raddr = in_value;
      out_we     = 1'b0;
      out_waddr  = alu_y[IW-1:0];
      unique case (state_ff)
         S_CLEAR: begin
            hist_we    = 1'b1;
            hist_waddr = clr_addr_ff;
            hist_wdata = '0;
         end
         S_LOAD, S_LOAD_END: begin
            // forward the previous increment when the same bin repeats
            alu_a   = (w_valid_ff && (w_addr_ff == p_addr_ff)) ? w_data_ff : hist_rd;
            hist_we = p_valid_ff;
         end
         S_PREFIX: begin
            alu_a      = acc_ff;
            alu_b      = hist_rd;
            hist_we    = p_valid_ff;
            hist_raddr = bin_ff;
         end
         S_PL_HIST: begin
            hist_raddr = item_rd;
         end
         S_PL_WRITE: begin
            alu_ctl.op = ALU_SUB;
            hist_we    = (hist_rd != '0);
            hist_waddr = x_ff;
            out_we     = (hist_rd != '0);
         end
         default: begin
            hist_we = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      clr_addr_in  = clr_addr_ff;
      clr_end_in   = clr_end_ff;
      p_valid_in   = 1'b0;
      p_addr_in    = p_addr_ff;
      w_valid_in   = 1'b0;
      w_addr_in    = p_addr_ff;
      w_data_in    = alu_y;
      acc_in       = acc_ff;
      bin_in       = bin_ff;
      bin_done_in  = bin_done_ff;
      idx_in       = idx_ff;
      x_in         = x_ff;
      em_idx_in    = em_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_addr_in = VB'(clr_addr_ff + 1'b1);
            if (clr_addr_ff == clr_end_ff) begin
               state_in = S_LOAD;
               count_in = '0;
               min_in   = '1;
               max_in   = '0;
            end
         end
         S_LOAD: begin
            // stage 2 of the increment pipe retires here too
            w_valid_in = p_valid_ff;
            p_valid_in = in_store;
            p_addr_in  = in_value;
            if (in_store) begin
               count_in = CW'(count_ff + 1'b1);
               if (in_value < min_ff) min_in = in_value;
               if (in_value > max_ff) max_in = in_value;
            end
            if (in_accept && req_tlast) begin
               state_in = S_LOAD_END;
            end
         end
         S_LOAD_END: begin
            state_in    = S_PREFIX;
            bin_in      = min_ff;
            bin_done_in = 1'b0;
            acc_in      = '0;
         end
         S_PREFIX: begin
            if (p_valid_ff) begin
               acc_in = alu_y;
            end
            if (!bin_done_ff) begin
               p_valid_in = 1'b1;
               p_addr_in  = bin_ff;
               if (bin_ff == max_ff) begin
                  bin_done_in = 1'b1;
               end else begin
                  bin_in = VB'(bin_ff + 1'b1);
               end
            end else if (!p_valid_ff) begin
               state_in = S_PL_ITEM;
               idx_in   = IW'(count_ff - 1'b1);
            end
         end
         S_PL_ITEM: begin
            state_in = S_PL_HIST;
         end
         S_PL_HIST: begin
            x_in     = item_rd;
            state_in = S_PL_WRITE;
         end
         S_PL_WRITE: begin
            if (idx_ff == '0) begin
               state_in  = S_EM_RD;
               em_idx_in = '0;
            end else begin
               idx_in   = IW'(idx_ff - 1'b1);
               state_in = S_PL_ITEM;
            end
         end
         S_EM_RD: begin
            state_in = S_EM_LOAD;
         end
         S_EM_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = 8'(out_rd);
            rsp_last_in  = ((CW'(em_idx_ff) + CW'(1)) == count_ff);
            state_in     = S_EM_WAIT;
         end
         S_EM_WAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in    = S_CLEAR;
                  clr_addr_in = min_ff;
                  clr_end_in  = max_ff;
               end else begin
                  em_idx_in = IW'(em_idx_ff + 1'b1);
                  state_in  = S_EM_RD;
               end
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         count_ff     <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         clr_addr_ff  <= '0;
         clr_end_ff   <= '1;
         p_valid_ff   <= 1'b0;
         w_valid_ff   <= 1'b0;
         bin_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         clr_addr_ff  <= clr_addr_in;
         clr_end_ff   <= clr_end_in;
         p_valid_ff   <= p_valid_in;
         w_valid_ff   <= w_valid_in;
         bin_done_ff  <= bin_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      p_addr_ff   <= p_addr_in;
      w_addr_ff   <= w_addr_in;
      w_data_ff   <= w_data_in;
      acc_ff      <= acc_in;
      bin_ff      <= bin_in;
      idx_ff      <= idx_in;
      x_ff        <= x_in;
      em_idx_ff   <= em_idx_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // no new set is taken while a result beat is pending
   a_ready_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input ready while a result is pending");

   // fill count stays within the store
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("item count beyond store depth");

   // a non-empty set always has an ordered range
   a_prefix_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PREFIX) |-> (min_ff <= max_ff))
      else $error("prefix pass with minimum above maximum");

   // every stored item finds a free slot in its bin
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PL_WRITE) |-> (hist_rd != '0))
      else $error("placement found an empty bin");

   // the output beat is loaded after its read was issued and presented in the following cycle
   a_emit_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EM_LOAD) |=> rsp_tvalid)
      else $error("result beat not presented after load");
`endif

endmodule

/* sim/sort_order_checker.sv */
// sort_order_checker: watches both channels of the counting sort engine, rebuilds each
// set's histogram from the input beats and checks every result beat in ascending order
// depends only on the clock, reset and channel signals handed in by the testbench top
module sort_order_checker #(
   parameter int MAX_ITEMS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] value
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [7:0] sorted_value
   input  logic       rsp_tlast,
   output int         error_count,
   output int         pending_results,
   output int         sets_sorted,
   output int         beats_loaded,
   output int         beats_dropped,
   output int         results_checked
);

   typedef struct packed {
      logic [7:0] value;
      logic       final_res;
   } sorted_beat_type;

   // ascending results still owed by the block, oldest first
   sorted_beat_type sorted_expect[$];

   // histogram and bounds of the set being loaded
   int         bin_count[256];
   logic [7:0] low_seen;
   logic [7:0] high_seen;
   int         loaded;

   int errors;
   int n_sets;
   int n_in;
   int n_drop;
   int n_out;

   initial begin
      errors = 0;
      n_sets = 0;
      n_in   = 0;
      n_drop = 0;
      n_out  = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
   endtask

   task automatic clear_histogram();
      for (int b = 0; b < 256; b++) bin_count[b] = 0;
      low_seen  = 8'hff;
      high_seen = 8'h00;
      loaded    = 0;
   endtask

   // walk the occupied bins from low to high; each count gives that many equal values
   task automatic sort_loaded_set();
      sorted_beat_type beat;
      int produced;
      produced = 0;
      for (int v = low_seen; v <= high_seen; v++) begin
         for (int k = 0; k < bin_count[v]; k++) begin
            produced++;
            beat.value     = v[7:0];
            beat.final_res = (produced == loaded);
            sorted_expect.push_back(beat);
         end
      end
      n_sets++;
   endtask

   // one input beat: store while there is room, sort when the set closes
   task automatic load_beat(input logic [7:0] v, input logic is_last);
      n_in++;
      if (loaded < MAX_ITEMS) begin
         bin_count[v]++;
         loaded++;
         if (v < low_seen) low_seen = v;
         if (v > high_seen) high_seen = v;
      end else begin
         n_drop++;
      end
      if (is_last) begin
         if (loaded > 0) sort_loaded_set();
         clear_histogram();
      end
   endtask

   task automatic check_result(input logic [7:0] v, input logic is_last);
      sorted_beat_type want;
      n_out++;
      if (sorted_expect.size() == 0) begin
         report_mismatch($sformatf("result beat with nothing owed: value %0d last %b",
                                   v, is_last));
      end else begin
         want = sorted_expect.pop_front();
         if (v !== want.value)
            report_mismatch($sformatf("sorted value %0d, expected %0d", v, want.value));
         if (is_last !== want.final_res)
            report_mismatch($sformatf("last flag %b on value %0d, expected %b",
                                      is_last, v, want.final_res));
      end
   endtask

   // sample both channels at the edge; counters go out with nonblocking updates
   always @(posedge clock) begin
      if (reset) begin
         clear_histogram();
         sorted_expect.delete();
      end else begin
         if (req_tvalid && req_tready) load_beat(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata, rsp_tlast);
      end
      error_count     <= errors;
      pending_results <= sorted_expect.size();
      sets_sorted     <= n_sets;
      beats_loaded    <= n_in;
      beats_dropped   <= n_drop;
      results_checked <= n_out;
   end

endmodule

/* sim/counting_sort_engine_top_test.sv */
// counting_sort_engine_top_test: stimulus and verdict for the counting sort engine
// drives sets of values with bursty timing, stalls the result side, and relies on
// sort_order_checker for prediction; depends on counting_sort_engine_top
module counting_sort_engine_top_test;

   localparam int MAX_ITEMS    = 32;
   localparam int VALUE_BITS   = 8;
   localparam int RANDOM_ITEMS = 134;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 300;

   typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_BUSY} sink_mode_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tready = 1'b0;
   logic       long_hold  = 1'b0;
   logic       hold_armed = 1'b0;

   logic       req_tready;
   logic       rsp_tvalid;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   int error_count;
   int pending_results;
   int sets_sorted;
   int beats_loaded;
   int beats_dropped;
   int results_checked;

   int burst_left = 0;
   int items_sent = 0;

   always #1 clock = ~clock;

   counting_sort_engine_top #(
      .MAX_ITEMS  (MAX_ITEMS),
      .VALUE_BITS (VALUE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   sort_order_checker #(
      .MAX_ITEMS (MAX_ITEMS)
   ) order_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .error_count     (error_count),
      .pending_results (pending_results),
      .sets_sorted     (sets_sorted),
      .beats_loaded    (beats_loaded),
      .beats_dropped   (beats_dropped),
      .results_checked (results_checked)
   );

   // result side: a new stall pattern for every stretch, ready forced low during the long hold
   initial begin
      sink_mode_type mode;
      int span;
      int ratio;
      forever begin
         mode  = sink_mode_type'($urandom_range(0, 3));
         span  = $urandom_range(20, 80);
         ratio = $urandom_range(2, 5);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               SINK_OPEN:   rsp_tready <= !long_hold;
               SINK_COIN:   rsp_tready <= !long_hold && ($urandom_range(0, 1) == 1);
               SINK_SPARSE: rsp_tready <= !long_hold && ($urandom_range(1, ratio) == 1);
               default:     rsp_tready <= !long_hold && ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // long hold-off of the result side so the engine backs up into its input
   initial begin
      wait (hold_armed);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   // watchdog
   initial begin
      #1000000;
      $display("DONE: errors detected");
      $finish;
   end

   // one input beat; a burst that runs out may be followed by a gap
   task automatic send_beat(input logic [7:0] v, input logic is_last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_random_set(input int count, input int lo, input int hi);
      for (int i = 0; i < count; i++)
         send_beat(8'($urandom_range(lo, hi)), i == count - 1);
   endtask

   // stimulus
   initial begin
      int set_no;
      int count;
      int lo;
      int hi;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // single-value sets at both ends of the range
      send_beat(8'd0, 1'b1);
      send_beat(8'd255, 1'b1);
      // both extremes in one set, with a duplicate
      send_beat(8'd255, 1'b0);
      send_beat(8'd0, 1'b0);
      send_beat(8'd128, 1'b0);
      send_beat(8'd0, 1'b1);
      // all equal: minimum and maximum coincide
      send_beat(8'd9, 1'b0);
      send_beat(8'd9, 1'b0);
      send_beat(8'd9, 1'b0);
      send_beat(8'd9, 1'b1);
      // already ascending
      send_beat(8'd1, 1'b0);
      send_beat(8'd2, 1'b0);
      send_beat(8'd3, 1'b0);
      send_beat(8'd4, 1'b0);
      send_beat(8'd5, 1'b1);
      // descending
      send_beat(8'd200, 1'b0);
      send_beat(8'd150, 1'b0);
      send_beat(8'd100, 1'b0);
      send_beat(8'd50, 1'b0);
      send_beat(8'd25, 1'b1);
      // alternating, solid and nibble bit patterns
      send_beat(8'haa, 1'b0);
      send_beat(8'h55, 1'b0);
      send_beat(8'hff, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'h0f, 1'b0);
      send_beat(8'hf0, 1'b1);

      // random sets: full capacity, overflow with last on a dropped beat, then mostly
      // short sets over wide or narrow value windows
      items_sent = 0;
      set_no     = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (set_no == 0) begin
            count = MAX_ITEMS;
            lo    = 0;
            hi    = 255;
         end else if (set_no == 1 || set_no % 9 == 8) begin
            count = (set_no == 1) ? MAX_ITEMS + 2 : $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
            lo    = 0;
            hi    = 255;
         end else begin
            count = $urandom_range(1, 10);
            if ($urandom_range(0, 3) == 0) begin
               lo = 0;
               hi = 255;
            end else if ($urandom_range(0, 1) == 0) begin
               lo = $urandom_range(0, 240);
               hi = lo + 15;
            end else begin
               lo = $urandom_range(0, 252);
               hi = lo + 3;
            end
         end
         if (set_no == 4) hold_armed <= 1'b1;
         send_random_set(count, lo, hi);
         set_no++;
      end
      req_tvalid <= 1'b0;

      // wait for every owed result, then let the histogram clear finish
      do @(posedge clock); while (pending_results != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sorted %0d sets from %0d input beats, %0d beyond capacity dropped",
               sets_sorted, beats_loaded, beats_dropped);
      $display("checked %0d result beats, one result hold-off of %0d cycles",
               results_checked, HOLD_CYCLES);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
